// ===== hdl/spdq_pkg.sv =====
// ----------------------------------------------------------------------------
// spdq_pkg
// Shared constants for the stick pulse direction qualifier: direction
// codes, register indexes, reset values and the persistence counter limits.
// ----------------------------------------------------------------------------
`default_nettype none

package spdq_pkg;

   // default pulse width in bits
   localparam int PULSE_BITS_DEF = 16;

   // direction codes (3 bits so that "none" fits)
   localparam int DIR_BITS = 3;
   localparam logic [DIR_BITS-1:0] DIR_UP    = 3'd0;
   localparam logic [DIR_BITS-1:0] DIR_RIGHT = 3'd1;
   localparam logic [DIR_BITS-1:0] DIR_DOWN  = 3'd2;
   localparam logic [DIR_BITS-1:0] DIR_LEFT  = 3'd3;
   localparam logic [DIR_BITS-1:0] DIR_NONE  = 3'd4;

   // register indexes
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTRE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOW    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HIGH   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD   = 2'd3;

   // reset values (wide; truncated to the pulse width where used)
   localparam logic [31:0] CENTRE_RESET = 32'd1520;
   localparam logic [31:0] LOW_RESET    = 32'd1315;
   localparam logic [31:0] HIGH_RESET   = 32'd1725;

   // persistence counter
   localparam int COUNT_BITS = 7;
   localparam logic [COUNT_BITS-1:0] HOLD_RESET = 7'd100;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 7'd127;

endpackage

`default_nettype wire

// ===== hdl/spdq_classify.sv =====
// ----------------------------------------------------------------------------
// spdq_classify
// Raw direction from two pulse widths: the axis farther from centre wins
// (tie to vertical), then that axis is checked against the thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module spdq_classify #(
   parameter int PULSE_BITS = spdq_pkg::PULSE_BITS_DEF
) (
   input  wire logic [PULSE_BITS-1:0]          centre_width,
   input  wire logic [PULSE_BITS-1:0]          low_threshold,
   input  wire logic [PULSE_BITS-1:0]          high_threshold,
   input  wire logic [PULSE_BITS-1:0]          horizontal_width,
   input  wire logic [PULSE_BITS-1:0]          vertical_width,
   output logic      [spdq_pkg::DIR_BITS-1:0]  raw_direction
);
   import spdq_pkg::*;

   logic [PULSE_BITS-1:0] dist_h;
   logic [PULSE_BITS-1:0] dist_v;

   // absolute distance of each axis from centre
   always_comb begin
      dist_h = (centre_width > horizontal_width) ? (centre_width - horizontal_width)
                                                 : (horizontal_width - centre_width);
      dist_v = (centre_width > vertical_width) ? (centre_width - vertical_width)
                                               : (vertical_width - centre_width);
   end

   // dominant axis, then threshold check
   always_comb begin
      raw_direction = DIR_NONE;
      if (dist_h > dist_v) begin
         if (horizontal_width < low_threshold) begin
            raw_direction = DIR_RIGHT;
         end else if (horizontal_width > high_threshold) begin
            raw_direction = DIR_LEFT;
         end
      end else begin
         if (vertical_width < low_threshold) begin
            raw_direction = DIR_DOWN;
         end else if (vertical_width > high_threshold) begin
            raw_direction = DIR_UP;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/stick_pulse_direction_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// stick_pulse_direction_qualifier_top
// Classifies stick pulse widths into a direction and qualifies a change of
// the held direction by a persistence count.
// ----------------------------------------------------------------------------
// One word is accepted per clock while the result side is ready, and one
// result word comes out per input word: a word is captured in an input
// register, classified and applied to the held state while it moves into
// the result register. Throughput is one word per cycle while not stalled;
// the only loop is the registered update of held direction, candidate and
// persistence count. Registers written on the csr port take effect for the words
// classified after the write; write them only while no word is in flight.
`default_nettype none

module stick_pulse_direction_qualifier_top #(
   parameter int PULSE_BITS = spdq_pkg::PULSE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [spdq_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [PULSE_BITS-1:0]                csr_wdata,
   // input words
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [PULSE_BITS-1:0]                req_horizontal_width,
   input  wire logic [PULSE_BITS-1:0]                req_vertical_width,
   input  wire logic [1:0]                           req_applied_direction,
   input  wire logic                                 req_paused,
   // result words
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_held_direction,
   output logic [spdq_pkg::DIR_BITS-1:0]             rsp_raw_direction,
   output logic                                      rsp_direction_changed
);
   import spdq_pkg::*;

   // configuration registers
   logic [PULSE_BITS-1:0] centre_ff;
   logic [PULSE_BITS-1:0] low_ff;
   logic [PULSE_BITS-1:0] high_ff;
   logic [COUNT_BITS-1:0] hold_ff;

   // input stage
   logic                  s0_valid_ff;
   logic [PULSE_BITS-1:0] s0_h_ff;
   logic [PULSE_BITS-1:0] s0_v_ff;
   logic [1:0]            s0_applied_ff;
   logic                  s0_paused_ff;

   // qualifier state
   logic [1:0]            held_ff,    held_in;
   logic [DIR_BITS-1:0]   cand_ff,    cand_in;
   logic [COUNT_BITS-1:0] persist_ff, persist_in;
   logic                  changed;

   // result stage
   logic                  out_valid_ff;
   logic [1:0]            out_held_ff;
   logic [DIR_BITS-1:0]   out_raw_ff;
   logic                  out_changed_ff;

   logic [DIR_BITS-1:0]   raw;
   logic                  s0_advance;
   logic                  req_take;
   logic                  reverse;

   // handshakes
   assign csr_ready  = 1'b1;
   assign s0_advance = s0_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s0_valid_ff || s0_advance;
   assign req_take   = req_valid && req_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff <= CENTRE_RESET[PULSE_BITS-1:0];
         low_ff    <= LOW_RESET[PULSE_BITS-1:0];
         high_ff   <= HIGH_RESET[PULSE_BITS-1:0];
         hold_ff   <= HOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CENTRE: centre_ff <= csr_wdata;
            CSR_LOW:    low_ff    <= csr_wdata;
            CSR_HIGH:   high_ff   <= csr_wdata;
            CSR_HOLD:   hold_ff   <= csr_wdata[COUNT_BITS-1:0];
            default:    ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_h_ff       <= req_horizontal_width;
         s0_v_ff       <= req_vertical_width;
         s0_applied_ff <= req_applied_direction;
         s0_paused_ff  <= req_paused;
      end
   end

   spdq_classify #(
      .PULSE_BITS(PULSE_BITS)
   ) u_classify (
      .centre_width     (centre_ff),
      .low_threshold    (low_ff),
      .high_threshold   (high_ff),
      .horizontal_width (s0_h_ff),
      .vertical_width   (s0_v_ff),
      .raw_direction    (raw)
   );

   // raw + 2 mod 4 equals applied
   assign reverse = ({~raw[1], raw[0]} == s0_applied_ff);

   // persistence update
   always_comb begin
      held_in    = held_ff;
      cand_in    = cand_ff;
      persist_in = persist_ff;
      changed    = 1'b0;
      if (!s0_paused_ff) begin
         if ((raw != {1'b0, s0_applied_ff}) && (raw != DIR_NONE)) begin
            if (persist_ff > hold_ff) begin
               if (!reverse) begin
                  held_in    = raw[1:0];
                  persist_in = '0;
                  changed    = 1'b1;
               end
            end else if (persist_ff == '0) begin
               cand_in    = raw;
               persist_in = COUNT_BITS'(1);
            end else if (cand_ff == raw) begin
               if (persist_ff < COUNT_MAX) begin
                  persist_in = persist_ff + COUNT_BITS'(1);
               end
            end else begin
               persist_in = '0;
            end
         end else begin
            persist_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= DIR_UP[1:0];
         cand_ff    <= DIR_NONE;
         persist_ff <= '0;
      end else if (s0_advance) begin
         held_ff    <= held_in;
         cand_ff    <= cand_in;
         persist_ff <= persist_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s0_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_advance) begin
         out_held_ff    <= held_in;
         out_raw_ff     <= raw;
         out_changed_ff <= changed;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_held_direction    = out_held_ff;
   assign rsp_raw_direction     = out_raw_ff;
   assign rsp_direction_changed = out_changed_ff;

endmodule

`default_nettype wire

// ===== hdl/spdq_checker.sv =====
// ----------------------------------------------------------------------------
// spdq_checker
// Port-level checks for the stick pulse direction qualifier, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spdq_checker #(
   parameter int PULSE_BITS = spdq_pkg::PULSE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire logic [PULSE_BITS-1:0]                req_horizontal_width,
   input  wire logic [PULSE_BITS-1:0]                req_vertical_width,
   input  wire logic [1:0]                           req_applied_direction,
   input  wire logic                                 req_paused,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire logic [1:0]                           rsp_held_direction,
   input  wire logic [spdq_pkg::DIR_BITS-1:0]        rsp_raw_direction,
   input  wire logic                                 rsp_direction_changed
);
   import spdq_pkg::*;

   // offered input word holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_horizontal_width)
         && $stable(req_vertical_width) && $stable(req_applied_direction)
         && $stable(req_paused))
      else $error("input word changed while stalled");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_held_direction)
         && $stable(rsp_raw_direction) && $stable(rsp_direction_changed))
      else $error("result word changed while stalled");

   // a change always takes this word's raw direction
   a_change_takes_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction_changed |->
         rsp_raw_direction != DIR_NONE
         && rsp_raw_direction[1:0] == rsp_held_direction)
      else $error("held direction does not match raw on change");

   // raw code is a direction or none
   a_raw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_raw_direction == DIR_UP || rsp_raw_direction == DIR_RIGHT
         || rsp_raw_direction == DIR_DOWN || rsp_raw_direction == DIR_LEFT
         || rsp_raw_direction == DIR_NONE)
      else $error("raw direction code out of range");

   // nothing comes out of a freshly reset block
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind stick_pulse_direction_qualifier_top spdq_checker #(
   .PULSE_BITS(PULSE_BITS)
) u_spdq_checker (.*);

`default_nettype wire
